// ===== rtl/core/drp_pkg.sv =====
// Shared types, codes and helpers for the drive ramp profiler.
package drp_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = 9;

    localparam int NUM_W  = 23;
    localparam int DEN_W  = 16;
    localparam int QUOT_W = 7;
    localparam int CNT_W  = 5;

    localparam logic [11:0] TICKS_MAX      = 12'd4095;
    localparam logic [11:0] CLIFF_MIN_TICK = 12'd5;
    localparam logic [6:0]  DUTY_MAX       = 7'd100;

    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BACK  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ABORT   = 2'd3;

    localparam logic [2:0] REG_SENSOR    = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_TPS       = 3'd2;
    localparam logic [2:0] REG_RAMP      = 3'd3;
    localparam logic [2:0] REG_ESC_DRIVE = 3'd4;
    localparam logic [2:0] REG_ESC_TICKS = 3'd5;

    localparam logic [1:0] LVL_SLOW = 2'd1;
    localparam logic [1:0] LVL_FAST = 2'd3;

    function automatic logic [6:0] duty_of(input logic [1:0] lvl);
        logic [6:0] d;
        if (lvl == LVL_SLOW) begin
            d = 7'd20;
        end else if (lvl == LVL_FAST) begin
            d = 7'd70;
        end else begin
            d = 7'd40;
        end
        return d;
    endfunction

    function automatic logic [7:0] neg8(input logic [6:0] m);
        return 8'(~{1'b0, m} + 8'd1);
    endfunction

endpackage

// ===== rtl/core/drp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module drp_div
    import drp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W - 1);
                rem_reg <= '0;
                num_reg <= num;
                den_reg <= den;
            end else if (run_reg) begin
                rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = num_reg[QUOT_W-1:0];

endmodule

// ===== rtl/core/drive_ramp_profiler_with_cliff_abort.sv =====
// Top level of the two-wheel drive ramp profiler with cliff abort.
//
// Channels: s_* carries one item per beat (op 0 queues a move, op 1 is an
// update tick); m_* returns exactly one result beat per input beat.
// cfg_* writes one register per beat and is always ready; write only
// while the block is idle.
// Sequence: a start beat, an idle tick or an escape tick goes straight
// to S_DONE. A move tick passes S_MUL and S_FIN without a ramp division;
// on a ramp it passes S_MUL, S_MUL2, S_DIV (waiting on the 23-step serial
// divider) and S_FIN. A tick that pops a new move first passes S_LOAD.
// Throughput: one item at a time; s_ready is high only when the
// sequencer is idle, so a new beat waits until the last has left S_DONE.
// The result sits in an output register; a new beat is accepted while it
// waits, and its result is held back until m_ready takes the previous one.
// Reset (aresetn low, synchronous) empties the queue, stops any move or
// escape and loads the register defaults; queue contents are not cleared.
module drive_ramp_profiler_with_cliff_abort
    import drp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [1:0]        s_direction,
    input  logic [4:0]        s_step_count,
    input  logic [1:0]        s_speed_level,
    input  logic [15:0]       s_range_mm,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [7:0] m_left_drive,
    output logic signed [7:0] m_right_drive,
    output logic [1:0]        m_status,
    output logic              m_busy_res,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_MUL2 = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_DONE = 7'b1000000
    } seq_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_MOVE = 3'b010,
        PH_ESC  = 3'b100
    } phase_t;

    // configuration
    logic        sensor_reg;
    logic [15:0] thr_reg;
    logic [7:0]  tps_reg;
    logic [7:0]  ramp_cfg_reg;
    logic [6:0]  esc_drive_reg;
    logic [7:0]  esc_ticks_reg;

    // block state
    seq_t              state_reg;
    phase_t            phase_reg;
    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_reg;
    logic [QIDX_W-1:0] head_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [ENTRY_W-1:0] move_reg;
    logic [11:0]       elapsed_reg;
    logic [11:0]       total_reg;
    logic [7:0]        ramp_reg;
    logic [7:0]        esc_left_reg;
    logic              cliff_reg;

    // per-tick work
    logic [15:0] sq_reg;
    logic [15:0] rr_reg;
    logic [6:0]  mag_reg;
    logic        need_div;

    // result
    logic [7:0] res_left_reg;
    logic [7:0] res_right_reg;
    logic [1:0] res_status_reg;
    logic       res_busy_reg;
    logic       m_valid_reg;
    logic [7:0] m_left_reg;
    logic [7:0] m_right_reg;
    logic [1:0] m_status_reg;
    logic       m_busy_reg;

    logic              accept;
    logic              load_out;
    logic              cliff_in;
    logic              q_full;
    logic [QIDX_W-1:0] tail;
    logic [FILL_W:0]   tail_sum;
    logic              q_write;
    logic [ENTRY_W-1:0] q_wdata;
    logic [QIDX_W-1:0] head_inc;

    logic [1:0]  m_dir;
    logic [6:0]  duty;
    logic        turn;
    logic [12:0] prod;
    logic [13:0] t14;
    logic [11:0] tsat;
    logic [7:0]  r_new;
    logic [11:0] d_full;
    logic        e_lt_r;
    logic        d_lt_r;
    logic [7:0]  x_sel;
    logic [NUM_W-1:0] num;
    logic        div_start;
    logic        div_done;
    logic [QUOT_W-1:0] quot;
    logic [6:0]  esc_mag;
    logic [7:0]  esc_next;
    logic        abort;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    assign cliff_in = sensor_reg && (s_range_mm >= thr_reg);
    assign q_full   = fill_reg >= FILL_W'(QUEUE_DEPTH);
    assign tail_sum = (FILL_W+1)'(head_reg) + (FILL_W+1)'(fill_reg);
    assign tail     = (tail_sum >= (FILL_W+1)'(QUEUE_DEPTH))
                      ? QIDX_W'(tail_sum - (FILL_W+1)'(QUEUE_DEPTH))
                      : QIDX_W'(tail_sum);
    assign head_inc = (head_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : QIDX_W'(head_reg + 1'b1);
    assign q_write  = accept && !s_op && !(cliff_in && s_direction != DIR_BACK) && !q_full;
    assign q_wdata  = {s_speed_level, s_step_count, s_direction};

    always_ff @(posedge aclk) begin
        if (q_write) begin
            mem[tail] <= q_wdata;
        end
        rd_reg <= mem[head_reg];
    end

    // move setup from the popped entry
    assign prod  = 13'(rd_reg[6:2] * tps_reg);
    assign t14   = rd_reg[1] ? {prod, 1'b0} : {1'b0, prod};
    assign tsat  = (t14 > 14'(TICKS_MAX)) ? TICKS_MAX : t14[11:0];
    assign r_new = (tsat < {3'b0, ramp_cfg_reg, 1'b0}) ? tsat[8:1] : ramp_cfg_reg;

    // magnitude terms for the active move
    assign m_dir  = move_reg[1:0];
    assign duty   = duty_of(move_reg[8:7]);
    assign turn   = m_dir[1];
    assign d_full = total_reg - elapsed_reg;
    assign e_lt_r = elapsed_reg < {4'b0, ramp_reg};
    assign d_lt_r = d_full < {4'b0, ramp_reg};
    assign x_sel  = (!turn && e_lt_r) ? elapsed_reg[7:0] : d_full[7:0];
    assign need_div = (ramp_reg != '0) && (elapsed_reg < total_reg)
                      && (turn ? d_lt_r : (e_lt_r || d_lt_r));
    assign num = turn ? NUM_W'(NUM_W'(rr_reg) * 23'd60 + NUM_W'(sq_reg) * 23'd40)
                      : NUM_W'(NUM_W'(sq_reg) * NUM_W'(duty));
    assign div_start = (state_reg == S_MUL2);

    assign esc_mag  = (esc_drive_reg > DUTY_MAX) ? DUTY_MAX : esc_drive_reg;
    assign esc_next = (esc_left_reg != '0) ? esc_left_reg - 1'b1 : '0;
    assign abort    = (m_dir == DIR_FWD) && cliff_reg && (elapsed_reg >= CLIFF_MIN_TICK);

    drp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     (rr_reg),
        .done    (div_done),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_reg    <= 1'b0;
            thr_reg       <= 16'd200;
            tps_reg       <= 8'd50;
            ramp_cfg_reg  <= 8'd60;
            esc_drive_reg <= 7'd35;
            esc_ticks_reg <= 8'd50;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SENSOR:    sensor_reg    <= cfg_data[0];
                REG_THRESHOLD: thr_reg       <= cfg_data;
                REG_TPS:       tps_reg       <= cfg_data[7:0];
                REG_RAMP:      ramp_cfg_reg  <= cfg_data[7:0];
                REG_ESC_DRIVE: esc_drive_reg <= cfg_data[6:0];
                REG_ESC_TICKS: esc_ticks_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_IDLE;
            head_reg     <= '0;
            fill_reg     <= '0;
            move_reg     <= '0;
            elapsed_reg  <= '0;
            total_reg    <= '0;
            ramp_reg     <= '0;
            esc_left_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !load_out) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        cliff_reg <= cliff_in;
                        if (!s_op) begin
                            res_left_reg  <= '0;
                            res_right_reg <= '0;
                            res_busy_reg  <= (phase_reg != PH_IDLE);
                            state_reg     <= S_DONE;
                            if (cliff_in && s_direction != DIR_BACK) begin
                                res_status_reg <= ST_REFUSED;
                            end else if (q_full) begin
                                res_status_reg <= ST_FULL;
                            end else begin
                                res_status_reg <= ST_OK;
                                fill_reg       <= fill_reg + 1'b1;
                            end
                        end else if (phase_reg == PH_IDLE) begin
                            res_left_reg   <= '0;
                            res_right_reg  <= '0;
                            res_status_reg <= ST_OK;
                            res_busy_reg   <= 1'b0;
                            if (fill_reg != '0) begin
                                head_reg  <= head_inc;
                                fill_reg  <= fill_reg - 1'b1;
                                state_reg <= S_LOAD;
                            end else begin
                                state_reg <= S_DONE;
                            end
                        end else if (phase_reg == PH_MOVE) begin
                            res_status_reg <= ST_OK;
                            state_reg      <= S_MUL;
                        end else begin
                            res_left_reg   <= neg8(esc_mag);
                            res_right_reg  <= neg8(esc_mag);
                            res_status_reg <= ST_OK;
                            res_busy_reg   <= 1'b1;
                            esc_left_reg   <= esc_next;
                            state_reg      <= S_DONE;
                            if (esc_next == '0) begin
                                phase_reg <= PH_IDLE;
                            end
                        end
                    end
                end
                S_LOAD: begin
                    move_reg    <= rd_reg;
                    total_reg   <= tsat;
                    ramp_reg    <= r_new;
                    elapsed_reg <= '0;
                    if (tsat != '0) begin
                        phase_reg <= PH_MOVE;
                        state_reg <= S_MUL;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_MUL: begin
                    sq_reg  <= 16'(x_sel * x_sel);
                    rr_reg  <= 16'(ramp_reg * ramp_reg);
                    mag_reg <= turn ? DUTY_MAX : duty;
                    state_reg <= need_div ? S_MUL2 : S_FIN;
                end
                S_MUL2: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        mag_reg   <= quot;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    res_busy_reg <= 1'b1;
                    if (abort) begin
                        res_left_reg   <= neg8(esc_mag);
                        res_right_reg  <= neg8(esc_mag);
                        res_status_reg <= ST_ABORT;
                        if (esc_ticks_reg > 8'd1) begin
                            esc_left_reg <= esc_ticks_reg - 1'b1;
                            phase_reg    <= PH_ESC;
                        end else begin
                            esc_left_reg <= '0;
                            phase_reg    <= PH_IDLE;
                        end
                    end else begin
                        res_left_reg  <= (m_dir == DIR_BACK || m_dir == DIR_LEFT)
                                         ? neg8(mag_reg) : {1'b0, mag_reg};
                        res_right_reg <= (m_dir == DIR_BACK || m_dir == DIR_RIGHT)
                                         ? neg8(mag_reg) : {1'b0, mag_reg};
                        elapsed_reg   <= elapsed_reg + 1'b1;
                        if (elapsed_reg + 1'b1 >= total_reg) begin
                            phase_reg <= PH_IDLE;
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        m_valid_reg  <= 1'b1;
                        m_left_reg   <= res_left_reg;
                        m_right_reg  <= res_right_reg;
                        m_status_reg <= res_status_reg;
                        m_busy_reg   <= res_busy_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_drive  = $signed(m_left_reg);
    assign m_right_drive = $signed(m_right_reg);
    assign m_status      = m_status_reg;
    assign m_busy_res    = m_busy_reg;

endmodule

// ===== rtl/core/drp_chk.sv =====
// Port-level checks for the drive ramp profiler, bound to the top level.
module drp_chk
    import drp_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [7:0] m_left_drive,
    input logic signed [7:0] m_right_drive,
    input logic [1:0]        m_status,
    input logic              m_busy_res
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_drive))
        else $error("result beat dropped while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_left_drive >= -8'sd100 && m_left_drive <= 8'sd100
                 && m_right_drive >= -8'sd100 && m_right_drive <= 8'sd100)
        else $error("drive out of range");

    a_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_ABORT |-> m_busy_res && m_left_drive == m_right_drive
                                         && m_left_drive <= 8'sd0)
        else $error("cliff abort beat malformed");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_REFUSED || m_status == ST_FULL)
        |-> m_left_drive == 8'sd0 && m_right_drive == 8'sd0)
        else $error("refused move drove motors");

    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second input beat taken while one is in flight");

endmodule

bind drive_ramp_profiler_with_cliff_abort drp_chk u_drp_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_left_drive  (m_left_drive),
    .m_right_drive (m_right_drive),
    .m_status      (m_status),
    .m_busy_res    (m_busy_res)
);

// ===== dv/tb_top.sv =====
// Self-checking bench for the drive ramp profiler: predicted drive samples vs. the block.
module tb_top
    import drp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       op;
        logic [1:0] direction;
        logic [4:0] step_count;
        logic [1:0] speed_level;
        logic [15:0] range_mm;
    } cmd_t;

    typedef struct packed {
        logic signed [7:0] left_drive;
        logic signed [7:0] right_drive;
        logic [1:0]        status;
        logic              busy_res;
    } drv_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;
    localparam int PH_IDLE = 0, PH_MOVE = 1, PH_ESCAPE = 2;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, s_op = 0;
    logic [1:0] s_direction = 0, s_speed_level = 0;
    logic [4:0] s_step_count = 0;
    logic [15:0] s_range_mm = 0;
    logic m_valid, m_ready = 0;
    logic signed [7:0] m_left_drive, m_right_drive;
    logic [1:0] m_status;
    logic m_busy_res;
    logic cfg_valid = 0, cfg_ready;
    logic [2:0] cfg_index = 0;
    logic [15:0] cfg_data = 0;

    always #10 aclk = ~aclk;

    drive_ramp_profiler_with_cliff_abort uut (.*);

    // predictor state
    logic [8:0] mq [QUEUE_DEPTH];
    int unsigned q_fill, q_head, ph, act, el, tot, rl, esc_left;
    int unsigned c_sensor, c_thr, c_tps, c_ramp, c_edrv, c_eticks;

    cmd_t pending_cmds[$];
    drv_t expected_drives[$];
    int errors = 0, n_results = 0, n_aborts = 0, n_full = 0, n_refused = 0;
    bit stim_done = 0, hold_send = 0;

    function automatic int unsigned mag_of(int unsigned dir, int unsigned duty);
        int unsigned rr, d;
        rr = rl * rl;
        if (rl == 0 || el >= tot) return (dir >= 2) ? 100 : duty;
        d = tot - el;
        if (dir >= 2) return (el + rl > tot) ? (60 * rr + 40 * d * d) / rr : 100;
        if (el < rl) return duty * el * el / rr;
        if (el + rl > tot) return duty * d * d / rr;
        return duty;
    endfunction

    function automatic logic [7:0] clamp8(int v);
        if (v > 100) v = 100;
        if (v < -100) v = -100;
        return 8'(v);
    endfunction

    function automatic drv_t predict_drive(cmd_t c);
        drv_t r;
        int lft, rgt, m, esc;
        int unsigned st, bz, e, t, dir, lvl, duty;
        bit cliff;
        lft = 0; rgt = 0; st = ST_OK; bz = 0;
        cliff = c_sensor != 0 && c.range_mm >= c_thr;
        esc = (c_edrv > 100) ? 100 : c_edrv;
        if (c.op == OP_START) begin
            if (cliff && c.direction != DIR_BACK) st = ST_REFUSED;
            else if (q_fill >= QUEUE_DEPTH) st = ST_FULL;
            else begin
                mq[(q_head + q_fill) % QUEUE_DEPTH] = {c.speed_level, c.step_count, c.direction};
                q_fill++;
            end
            bz = (ph != PH_IDLE);
        end else begin
            if (ph == PH_IDLE && q_fill != 0) begin
                e = mq[q_head];
                q_head = (q_head + 1) % QUEUE_DEPTH;
                q_fill--;
                t = ((e >> 2) & 31) * c_tps;
                if ((e & 3) >= 2) t *= 2;
                if (t > 4095) t = 4095;
                act = e; tot = t;
                rl = (t < 2 * c_ramp) ? t / 2 : c_ramp;
                el = 0;
                ph = (t != 0) ? PH_MOVE : PH_IDLE;
            end
            if (ph == PH_MOVE) begin
                dir = act & 3; lvl = (act >> 7) & 3;
                duty = (lvl == 1) ? 20 : (lvl == 3) ? 70 : 40;
                m = mag_of(dir, duty);
                bz = 1;
                case (dir)
                    DIR_FWD: begin lft = m; rgt = m; end
                    DIR_BACK: begin lft = -m; rgt = -m; end
                    DIR_LEFT: begin lft = -m; rgt = m; end
                    default: begin lft = m; rgt = -m; end
                endcase
                if (dir == DIR_FWD && cliff && el >= 5) begin
                    lft = -esc; rgt = -esc; st = ST_ABORT;
                    if (c_eticks > 1) begin
                        esc_left = c_eticks - 1; ph = PH_ESCAPE;
                    end else begin
                        esc_left = 0; ph = PH_IDLE;
                    end
                end else begin
                    el++;
                    if (el >= tot) ph = PH_IDLE;
                end
            end else if (ph == PH_ESCAPE) begin
                lft = -esc; rgt = -esc; bz = 1;
                if (esc_left > 0) esc_left--;
                if (esc_left == 0) ph = PH_IDLE;
            end
        end
        r.left_drive = clamp8(lft);
        r.right_drive = clamp8(rgt);
        r.status = st[1:0];
        r.busy_res = bz[0];
        return r;
    endfunction

    // driver
    int gap = 0;
    int rwait = 0;
    bit in_acc = 0, out_acc = 0;
    always @(negedge aclk) begin
        int rw;
        if (aresetn) begin
            if (in_acc) begin
                s_valid <= 0;
                gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
            end else if (!s_valid) begin
                if (gap > 0) gap <= gap - 1;
                else if (pending_cmds.size() > 0 && !hold_send) begin
                    cmd_t c;
                    c = pending_cmds.pop_front();
                    s_op <= c.op; s_direction <= c.direction; s_step_count <= c.step_count;
                    s_speed_level <= c.speed_level; s_range_mm <= c.range_mm;
                    s_valid <= 1;
                end
            end
            rw = out_acc ? int'($urandom_range(0, 7)) : rwait;
            if (rw > 0) begin
                m_ready <= 0;
                rwait <= rw - 1;
            end else begin
                m_ready <= 1;
                rwait <= 0;
            end
        end
    end

    // accept + monitor at rising edge
    always @(posedge aclk) begin
        in_acc <= aresetn && s_valid && s_ready;
        out_acc <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            cmd_t c;
            c = {s_op, s_direction, s_step_count, s_speed_level, s_range_mm};
            expected_drives.push_back(predict_drive(c));
        end
        if (aresetn && m_valid && m_ready) begin
            drv_t a, x;
            a = {m_left_drive, m_right_drive, m_status, m_busy_res};
            n_results++;
            if (expected_drives.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat %h", $time, a);
            end else begin
                x = expected_drives.pop_front();
                if (a.status == ST_ABORT) n_aborts++;
                if (a.status == ST_FULL) n_full++;
                if (a.status == ST_REFUSED) n_refused++;
                if (a.left_drive !== x.left_drive)
                    $display("%0t: left exp %0d got %0d", $time, x.left_drive, a.left_drive);
                if (a.right_drive !== x.right_drive)
                    $display("%0t: right exp %0d got %0d", $time, x.right_drive, a.right_drive);
                if (a.status !== x.status)
                    $display("%0t: status exp %0d got %0d", $time, x.status, a.status);
                if (a.busy_res !== x.busy_res)
                    $display("%0t: busy exp %0d got %0d", $time, x.busy_res, a.busy_res);
                if (a !== x) errors++;
            end
        end
    end

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || s_valid || expected_drives.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        @(negedge aclk);
        cfg_index <= idx; cfg_data <= v; cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_SENSOR: c_sensor = v & 1;
            REG_THRESHOLD: c_thr = v;
            REG_TPS: c_tps = v & 8'hff;
            REG_RAMP: c_ramp = v & 8'hff;
            REG_ESC_DRIVE: c_edrv = v & 7'h7f;
            REG_ESC_TICKS: c_eticks = v & 8'hff;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    function automatic cmd_t mk(logic op, logic [1:0] d, logic [4:0] s, logic [1:0] sp,
                                logic [15:0] r);
        cmd_t c;
        c = {op, d, s, sp, r};
        return c;
    endfunction

    // one move followed by 1 to max_ticks ticks, with random range samples
    task automatic add_move(int unsigned max_ticks);
        int unsigned n, s;
        cmd_t c;
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 3);
        c = mk(OP_START, 2'($urandom_range(0, 3)), 5'(s), 2'($urandom_range(0, 3)),
               16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400)));
        pending_cmds.push_back(c);
        n = $urandom_range(1, max_ticks);
        repeat (n) begin
            c = mk(OP_TICK, 2'($urandom), 5'($urandom), 2'($urandom),
                   16'(($urandom_range(0, 5) == 0) ? $urandom_range(150, 65535)
                                                    : $urandom_range(0, 199)));
            pending_cmds.push_back(c);
        end
    endtask

    initial begin
        int unsigned phase_no;
        c_sensor = 0; c_thr = 200; c_tps = 50; c_ramp = 60; c_edrv = 35; c_eticks = 50;
        q_fill = 0; q_head = 0; ph = PH_IDLE; act = 0; el = 0; tot = 0; rl = 0; esc_left = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed: short ramps, all directions, full queue, refuse, abort
        write_reg(REG_TPS, 2);
        write_reg(REG_RAMP, 3);
        write_reg(REG_SENSOR, 1);
        write_reg(REG_THRESHOLD, 200);
        write_reg(REG_ESC_DRIVE, 100);
        write_reg(REG_ESC_TICKS, 2);
        pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_START, DIR_FWD, 31, 3, 0));
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back(mk(OP_START, 2'(i), 1, 2'(i), 16'hffff));
        for (int i = 0; i < 8; i++)
            pending_cmds.push_back(mk(OP_START, 2'(i % 4), 0, 1, 199));
        for (int i = 0; i < 10; i++) pending_cmds.push_back(mk(OP_TICK, 3, 31, 3,
                                                            (i > 5) ? 16'hffff : 16'd0));
        wait_idle();
        write_reg(7, 16'hffff);
        write_reg(REG_ESC_DRIVE, 127);
        write_reg(REG_ESC_TICKS, 0);
        pending_cmds.push_back(mk(OP_START, DIR_FWD, 5, 2, 0));
        for (int i = 0; i < 8; i++) pending_cmds.push_back(mk(OP_TICK, 0, 0, 0,
                                                            (i == 7) ? 16'd500 : 16'd0));
        wait_idle();
        write_reg(REG_SENSOR, 0);
        write_reg(REG_TPS, 0);
        write_reg(REG_RAMP, 0);
        pending_cmds.push_back(mk(OP_START, DIR_LEFT, 3, 1, 0));
        pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0));
        pending_cmds.push_back(mk(OP_TICK, 0, 0, 0, 0));
        wait_idle();
        // random phases under varied settings
        for (phase_no = 0; phase_no < 8; phase_no++) begin
            int unsigned ticks;
            write_reg(REG_SENSOR, 16'($urandom_range(0, 1)));
            write_reg(REG_THRESHOLD, 16'((phase_no == 7) ? 16'hffff : (phase_no == 6) ? 0 :
                      $urandom_range(100, 300)));
            write_reg(REG_TPS, 16'((phase_no == 0) ? 1 : (phase_no == 7) ? 255 :
                      $urandom_range(1, 6)));
            write_reg(REG_RAMP, 16'((phase_no == 1) ? 255 : (phase_no == 2) ? 1 :
                      $urandom_range(1, 8)));
            write_reg(REG_ESC_DRIVE, 16'((phase_no == 3) ? 0 : $urandom_range(0, 127)));
            write_reg(REG_ESC_TICKS, 16'((phase_no == 4) ? 255 : $urandom_range(0, 6)));
            ticks = (phase_no == 7) ? 60 : 40;
            while (pending_cmds.size() < 230) begin
                if ($urandom_range(0, 9) == 0)
                    pending_cmds.push_back(mk(1'($urandom), 2'($urandom), 5'($urandom),
                                              2'($urandom), 16'($urandom)));
                else add_move(ticks);
            end
            if (phase_no == 5) begin
                while (pending_cmds.size() >= 100) @(posedge aclk);
                hold_send = 1;
                while (s_valid || expected_drives.size() > 0) @(posedge aclk);
                repeat (20) @(posedge aclk);
                hold_send = 0;
            end
            wait_idle();
        end
        $display("tb_top: %0d result beats checked, %0d aborts, %0d refused, %0d full",
                 n_results, n_aborts, n_refused, n_full);
        $display("tb_top: covered all directions and speeds, register extremes, escapes");
        if (errors == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
